>>> src/tms_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tms_pkg
// Shared constants, types and codes for the Tremaux maze step block.
// ============================================================================
package tms_pkg;

    localparam int GRID_COLS   = 16;
    localparam int GRID_ROWS   = 16;
    localparam int QUEUE_DEPTH = 3;

    localparam int COL_W       = $clog2(GRID_COLS);
    localparam int ROW_W       = $clog2(GRID_ROWS);
    localparam int NUM_CELLS   = GRID_COLS * GRID_ROWS;
    localparam int CELL_AW     = $clog2(NUM_CELLS);
    localparam int MARK_W      = 2;
    localparam int QHEAD_W     = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [1:0] {
        MV_FORWARD = 2'd0,
        MV_RIGHT   = 2'd1,
        MV_LEFT    = 2'd2
    } move_t;

    typedef enum logic [1:0] {
        DIR_NORTH = 2'd0,
        DIR_EAST  = 2'd1,
        DIR_SOUTH = 2'd2,
        DIR_WEST  = 2'd3
    } dir_t;

    // Request from the sequencer to the mark store.
    typedef struct packed {
        logic                clear;
        logic                wr_en;
        logic [CELL_AW-1:0]  addr;
        logic [MARK_W-1:0]   wr_data;
    } mark_req_t;

endpackage

>>> src/tms_nbr_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// tms_nbr_unit
// Shared address unit: maps the current cell and a direction to the
// clamped neighbor cell address, or to the cell itself.
// ============================================================================
module tms_nbr_unit
(
    input  logic [tms_pkg::COL_W-1:0]   x,
    input  logic [tms_pkg::ROW_W-1:0]   y,
    input  tms_pkg::dir_t               dir,
    input  logic                        center,
    output logic [tms_pkg::CELL_AW-1:0] addr
);

    logic [tms_pkg::COL_W-1:0] nx;
    logic [tms_pkg::ROW_W-1:0] ny;

    always_comb
    begin
        nx = x;
        ny = y;
        if (!center)
        begin
            unique case (dir)
                tms_pkg::DIR_NORTH:
                begin
                    if (y != tms_pkg::ROW_W'(tms_pkg::GRID_ROWS - 1))
                    begin
                        ny = y + tms_pkg::ROW_W'(1);
                    end
                end
                tms_pkg::DIR_EAST:
                begin
                    if (x != tms_pkg::COL_W'(tms_pkg::GRID_COLS - 1))
                    begin
                        nx = x + tms_pkg::COL_W'(1);
                    end
                end
                tms_pkg::DIR_SOUTH:
                begin
                    if (y != '0)
                    begin
                        ny = y - tms_pkg::ROW_W'(1);
                    end
                end
                tms_pkg::DIR_WEST:
                begin
                    if (x != '0)
                    begin
                        nx = x - tms_pkg::COL_W'(1);
                    end
                end
                default:
                begin
                    nx = x;
                end
            endcase
        end
        addr = tms_pkg::CELL_AW'(32'(ny) * 32'(tms_pkg::GRID_COLS) + 32'(nx));
    end

endmodule

>>> src/tms_mark_store.sv
`timescale 1ns / 1ps
// ============================================================================
// tms_mark_store
// Visit mark memory with one registered read port, one write port and a
// valid bit per cell so that a restart clears every mark at once.
// ============================================================================
module tms_mark_store
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  tms_pkg::mark_req_t         req,
    output logic [tms_pkg::MARK_W-1:0] rd_mark
);

    logic [tms_pkg::MARK_W-1:0]    mark_ram [tms_pkg::NUM_CELLS];
    logic [tms_pkg::NUM_CELLS-1:0] valid_reg;
    logic [tms_pkg::MARK_W-1:0]    rd_data_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mark_ram[req.addr] <= req.wr_data;
        end
        rd_data_reg <= mark_ram[req.addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.addr];
        end
    end

    // A cell never written since the last clear reads as zero.
    assign rd_mark = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> src/tremaux_maze_step.sv
`timescale 1ns / 1ps
// ============================================================================
// tremaux_maze_step
// Tremaux exploration step: picks the next move of a maze mouse.
// ============================================================================
// Usage:
// The slave channel takes one beat per maze step. s_tuser carries the
// command (0 step, 1 restart); s_tdata carries the cell, heading and the
// open sides. Each step beat yields one beat on the master channel with
// the move in m_tdata; a restart beat clears all visit marks and the move
// queue and yields nothing.
// Sequence: a step is not overlapped with the next; a new beat is taken
// only once the result is in the output register and the block is back
// in S_IDLE. The single mark memory port and the shared neighbor address
// unit make the step sequential: the right, ahead, left and current cell
// marks are read one per cycle, S_DECIDE decides and writes the mark back,
// and S_EMIT loads the output register.
// A restart beat leaves the block idle and ready for the next beat.
// After reset all marks are zero, the queue is empty and the last move is
// forward. The result sits in an output register; while the receiver
// stalls, the block still accepts the next beat and works on it, and only
// waits before overwriting the held result.
// ============================================================================
module tremaux_maze_step
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] pos_x, [7:4] pos_y, [9:8] heading, [10] open_left,
    // [11] open_ahead, [12] open_right, [15:13] zero
    input  logic [tms_pkg::IN_TDATA_W-1:0]  s_tdata,
    // [0] command
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] move, [7:2] zero
    output logic [tms_pkg::OUT_TDATA_W-1:0] m_tdata
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_RD_R   = 7'b0000010,
        S_RD_A   = 7'b0000100,
        S_RD_L   = 7'b0001000,
        S_RD_C   = 7'b0010000,
        S_DECIDE = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [tms_pkg::COL_W-1:0]     x_reg, x_next;
    logic [tms_pkg::ROW_W-1:0]     y_reg, y_next;
    logic [1:0]                    hd_reg;
    logic                          opl_reg, opa_reg, opr_reg;
    logic [tms_pkg::MARK_W-1:0]    m_right_reg, m_ahead_reg, m_left_reg;
    tms_pkg::move_t                q_reg [tms_pkg::QUEUE_DEPTH];
    logic [tms_pkg::QHEAD_W-1:0]   head_reg, head_next;
    logic [tms_pkg::QCOUNT_W-1:0]  count_reg, count_next;
    tms_pkg::move_t                last_move_reg;
    tms_pkg::move_t                move_reg;
    logic                          out_valid_reg;
    tms_pkg::move_t                out_move_reg;

    logic                          in_fire;
    logic                          out_free;
    tms_pkg::dir_t                 nbr_dir;
    logic                          nbr_center;
    logic [tms_pkg::CELL_AW-1:0]   nbr_addr;
    tms_pkg::mark_req_t            mark_req;
    logic [tms_pkg::MARK_W-1:0]    rd_mark;

    tms_pkg::move_t                pick;
    tms_pkg::move_t                push0, push1;
    logic                          pick_ahead, pick_right;
    logic [tms_pkg::MARK_W-1:0]    new_mark;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Position clamp to the grid.
    assign x_next = (32'(s_tdata[3:0]) > 32'(tms_pkg::GRID_COLS - 1))
                  ? tms_pkg::COL_W'(tms_pkg::GRID_COLS - 1)
                  : tms_pkg::COL_W'(s_tdata[3:0]);
    assign y_next = (32'(s_tdata[7:4]) > 32'(tms_pkg::GRID_ROWS - 1))
                  ? tms_pkg::ROW_W'(tms_pkg::GRID_ROWS - 1)
                  : tms_pkg::ROW_W'(s_tdata[7:4]);

    // Direction for the shared address unit in each read state.
    always_comb
    begin
        nbr_center = 1'b0;
        nbr_dir    = tms_pkg::dir_t'(hd_reg);
        unique case (state_reg)
            S_RD_R:  nbr_dir = tms_pkg::dir_t'(2'(hd_reg + 2'd1));
            S_RD_A:  nbr_dir = tms_pkg::dir_t'(hd_reg);
            S_RD_L:  nbr_dir = tms_pkg::dir_t'(2'(hd_reg + 2'd3));
            default: nbr_center = 1'b1;
        endcase
    end

    tms_nbr_unit u_nbr
    (
        .x      (x_reg),
        .y      (y_reg),
        .dir    (nbr_dir),
        .center (nbr_center),
        .addr   (nbr_addr)
    );

    always_comb
    begin
        mark_req.clear   = in_fire && s_tuser;
        mark_req.wr_en   = (state_reg == S_DECIDE);
        mark_req.addr    = nbr_addr;
        mark_req.wr_data = new_mark;
    end

    tms_mark_store u_marks
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mark_req),
        .rd_mark (rd_mark)
    );

    // Move choice: fewest marks among open sides, ties go ahead, right, left.
    assign pick_ahead = opa_reg && (!opr_reg || (m_ahead_reg <= m_right_reg))
                                && (!opl_reg || (m_ahead_reg <= m_left_reg));
    assign pick_right = opr_reg && (!opl_reg || (m_right_reg <= m_left_reg));

    always_comb
    begin
        push0      = tms_pkg::MV_FORWARD;
        push1      = tms_pkg::MV_FORWARD;
        pick       = tms_pkg::MV_FORWARD;
        head_next  = head_reg;
        count_next = count_reg;
        if (count_reg == '0)
        begin
            // Queue is refilled from the slot at index zero.
            head_next = '0;
            if (!opl_reg && !opa_reg && !opr_reg)
            begin
                pick       = tms_pkg::MV_RIGHT;
                push0      = tms_pkg::MV_RIGHT;
                push1      = tms_pkg::MV_FORWARD;
                count_next = tms_pkg::QCOUNT_W'(2);
            end
            else if (pick_ahead)
            begin
                pick       = tms_pkg::MV_FORWARD;
                count_next = '0;
            end
            else if (pick_right)
            begin
                pick       = tms_pkg::MV_RIGHT;
                count_next = tms_pkg::QCOUNT_W'(1);
            end
            else if (opl_reg)
            begin
                pick       = tms_pkg::MV_LEFT;
                count_next = tms_pkg::QCOUNT_W'(1);
            end
            else
            begin
                pick       = tms_pkg::MV_FORWARD;
                count_next = '0;
            end
        end
        else
        begin
            pick       = q_reg[head_reg];
            count_next = count_reg - tms_pkg::QCOUNT_W'(1);
            if (head_reg == tms_pkg::QHEAD_W'(tms_pkg::QUEUE_DEPTH - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + tms_pkg::QHEAD_W'(1);
            end
        end
    end

    // Mark update of the current cell; rd_mark holds its mark in S_DECIDE.
    always_comb
    begin
        new_mark = rd_mark;
        if (pick == tms_pkg::MV_RIGHT && last_move_reg == tms_pkg::MV_RIGHT)
        begin
            new_mark = tms_pkg::MARK_W'(2);
        end
        else if (pick == tms_pkg::MV_FORWARD && rd_mark == '0)
        begin
            new_mark = tms_pkg::MARK_W'(1);
        end
        else if (rd_mark == tms_pkg::MARK_W'(1))
        begin
            if ((!opl_reg || m_left_reg != '0) && (!opa_reg || m_ahead_reg != '0)
                && (!opr_reg || m_right_reg != '0))
            begin
                new_mark = tms_pkg::MARK_W'(2);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && !s_tuser)
                begin
                    state_next = S_RD_R;
                end
            end
            S_RD_R:   state_next = S_RD_A;
            S_RD_A:   state_next = S_RD_L;
            S_RD_L:   state_next = S_RD_C;
            S_RD_C:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            last_move_reg <= tms_pkg::MV_FORWARD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire && s_tuser)
            begin
                head_reg  <= '0;
                count_reg <= '0;
            end
            else if (state_reg == S_DECIDE)
            begin
                head_reg      <= head_next;
                count_reg     <= count_next;
                last_move_reg <= pick;
            end
            if (state_reg == S_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            hd_reg  <= s_tdata[9:8];
            opl_reg <= s_tdata[10];
            opa_reg <= s_tdata[11];
            opr_reg <= s_tdata[12];
        end
        // Read data is registered, so each mark is captured in the state that follows its address state.
        if (state_reg == S_RD_A)
        begin
            m_right_reg <= rd_mark;
        end
        if (state_reg == S_RD_L)
        begin
            m_ahead_reg <= rd_mark;
        end
        if (state_reg == S_RD_C)
        begin
            m_left_reg <= rd_mark;
        end
        if (state_reg == S_DECIDE)
        begin
            move_reg <= pick;
            if (count_reg == '0)
            begin
                q_reg[0] <= push0;
                q_reg[1] <= push1;
            end
        end
        if (state_reg == S_EMIT && out_free)
        begin
            out_move_reg <= move_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = tms_pkg::OUT_TDATA_W'(out_move_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= tms_pkg::QUEUE_DEPTH)
        else $error("move queue count above depth");

    a_move_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("result carries an undefined move code");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser) |=> (count_reg == '0) && (state_reg == S_IDLE))
        else $error("restart did not empty the queue");

    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !s_tuser) |=> (state_reg == S_RD_R))
        else $error("step beat did not start the mark reads");

    a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=> m_tvalid && (state_reg == S_IDLE))
        else $error("result not loaded into the output register");

endmodule
